FILE: hw/rtl/ipv4hv_pkg.sv
// Shared constants and helpers for the IPv4 header validator.
// No dependencies.
package ipv4hv_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned ProtoW = 8;
    localparam int unsigned StatW  = 3;
    localparam int unsigned IdxW   = 5;
    localparam int unsigned HbW    = 6;

    typedef logic [WordW-1:0]  t_word;
    typedef logic [ProtoW-1:0] t_proto;
    typedef logic [StatW-1:0]  t_status;
    typedef logic [IdxW-1:0]   t_idx;
    typedef logic [HbW-1:0]    t_hbytes;

    localparam t_status ST_ACCEPT       = 3'd0;
    localparam t_status ST_BAD_VERSION  = 3'd1;
    localparam t_status ST_SHORT_HEADER = 3'd2;
    localparam t_status ST_TTL_ZERO     = 3'd3;
    localparam t_status ST_BAD_CSUM     = 3'd4;
    localparam t_status ST_BAD_PROTO    = 3'd5;

    localparam logic [3:0] IP_VERSION   = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;
    localparam t_idx       IDX_LENGTH   = 5'd1;
    localparam t_idx       IDX_TTL_PROT = 5'd4;
    localparam t_proto     PROTO_RESET  = 8'd1;
    localparam t_word      CSUM_GOOD    = 16'hFFFF;

    // One's-complement add with end-around carry; cannot overflow twice.
    function automatic t_word ones_add(input t_word a, input t_word b);
        logic [WordW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

endpackage

FILE: hw/rtl/ipv4_header_validator.sv
// IPv4 header validator top level: header checks, checksum and verdict.
// Depends on ipv4hv_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------------------
//  input     in         i_in_valid / o_in_ready   i_header_word, i_start_req
//  result    out        o_out_valid / i_out_ready o_status, o_protocol, o_total_length,
//                                                 o_header_bytes
//  config    in         i_cfg_we (no wait)        i_cfg_data (accepted protocol)
//
// One word is taken per cycle unless the result register is full and stalled;
// the verdict for a header appears in the result register on the cycle after its
// last word (or its first word, when the version or header length is bad).
// Synchronous active-low reset clears the parse state and the result valid,
// and sets the accepted protocol to ICMP.
// The result register stalls on i_out_ready low; input is still taken while
// the result is being drained, and is held off only when the result is full.
module ipv4_header_validator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  ipv4hv_pkg::t_proto     i_cfg_data,
    // word stream
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ipv4hv_pkg::t_word      i_header_word,
    input  logic                   i_start_req,
    // verdicts
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ipv4hv_pkg::t_status    o_status,
    output ipv4hv_pkg::t_proto     o_protocol,
    output ipv4hv_pkg::t_word      o_total_length,
    output ipv4hv_pkg::t_hbytes    o_header_bytes
);
    import ipv4hv_pkg::*;

    // Parse state
    t_proto  r_acc_proto;
    t_idx    r_word_idx,  n_word_idx;
    t_idx    r_hdr_words, n_hdr_words;
    t_word   r_sum,       n_sum;
    logic    r_busy,      n_busy;
    logic    r_ttl_zero,  n_ttl_zero;
    t_proto  r_seen_prot, n_seen_prot;
    t_word   r_seen_len,  n_seen_len;

    // Result register
    logic    r_out_valid;
    t_status r_status,   n_status;
    t_proto  r_res_prot, n_res_prot;
    t_word   r_res_len,  n_res_len;
    t_hbytes r_res_hb,   n_res_hb;
    logic    n_emit;

    logic       xfer_in;
    logic [3:0] version;
    logic [3:0] ihl;
    t_idx       idx_inc;

    // Take a word whenever the result slot is free or is being drained now.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign xfer_in    = i_in_valid && o_in_ready;

    assign version = i_header_word[15:12];
    assign ihl     = i_header_word[11:8];
    assign idx_inc = r_word_idx + t_idx'(1);

    always_comb begin
        n_word_idx  = r_word_idx;
        n_hdr_words = r_hdr_words;
        n_sum       = r_sum;
        n_busy      = r_busy;
        n_ttl_zero  = r_ttl_zero;
        n_seen_prot = r_seen_prot;
        n_seen_len  = r_seen_len;
        n_emit      = 1'b0;
        n_status    = ST_ACCEPT;
        n_res_prot  = '0;
        n_res_len   = '0;
        n_res_hb    = {ihl, 2'b00};

        if (xfer_in) begin
            if (i_start_req) begin
                // New datagram: abandon any unfinished header.
                n_seen_prot = '0;
                n_seen_len  = '0;
                n_ttl_zero  = 1'b0;
                if (version != IP_VERSION) begin
                    n_busy   = 1'b0;
                    n_emit   = 1'b1;
                    n_status = ST_BAD_VERSION;
                end else if (ihl < IHL_MIN) begin
                    n_busy   = 1'b0;
                    n_emit   = 1'b1;
                    n_status = ST_SHORT_HEADER;
                end else begin
                    n_busy      = 1'b1;
                    n_hdr_words = {ihl, 1'b0};
                    n_word_idx  = t_idx'(1);
                    n_sum       = i_header_word;
                end
            end else if (r_busy) begin
                n_sum = ones_add(r_sum, i_header_word);
                if (r_word_idx == IDX_LENGTH) begin
                    n_seen_len = i_header_word;
                end
                if (r_word_idx == IDX_TTL_PROT) begin
                    n_ttl_zero  = (i_header_word[15:8] == '0);
                    n_seen_prot = i_header_word[7:0];
                end
                n_word_idx = idx_inc;
                // Last header word: form the verdict in priority order.
                if (idx_inc == r_hdr_words) begin
                    n_busy     = 1'b0;
                    n_emit     = 1'b1;
                    n_res_prot = n_seen_prot;
                    n_res_len  = n_seen_len;
                    n_res_hb   = {r_hdr_words, 1'b0};
                    priority if (n_ttl_zero) begin
                        n_status = ST_TTL_ZERO;
                    end else if (n_sum != CSUM_GOOD) begin
                        n_status = ST_BAD_CSUM;
                    end else if (n_seen_prot != r_acc_proto) begin
                        n_status = ST_BAD_PROTO;
                    end else begin
                        n_status = ST_ACCEPT;
                    end
                end
            end
            // words outside a header are dropped
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_proto <= PROTO_RESET;
            r_word_idx  <= '0;
            r_hdr_words <= '0;
            r_sum       <= '0;
            r_busy      <= 1'b0;
            r_ttl_zero  <= 1'b0;
            r_seen_prot <= '0;
            r_seen_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_acc_proto <= i_cfg_data;
            end
            r_word_idx  <= n_word_idx;
            r_hdr_words <= n_hdr_words;
            r_sum       <= n_sum;
            r_busy      <= n_busy;
            r_ttl_zero  <= n_ttl_zero;
            r_seen_prot <= n_seen_prot;
            r_seen_len  <= n_seen_len;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on a new verdict, hold otherwise
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_status   <= n_status;
            r_res_prot <= n_res_prot;
            r_res_len  <= n_res_len;
            r_res_hb   <= n_res_hb;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_protocol     = r_res_prot;
    assign o_total_length = r_res_len;
    assign o_header_bytes = r_res_hb;

endmodule

FILE: tb/ipv4hv_tb_pkg.sv
// Verdict scoreboard for the IPv4 header validator testbench: predicts each verdict
// from the accepted word stream and checks the block's results in order.
// Depends on ipv4hv_pkg.
`timescale 1ns / 100ps
package ipv4hv_tb_pkg;

    import ipv4hv_pkg::*;

    typedef struct {
        t_status status;
        t_proto  proto;
        t_word   total_len;
        t_hbytes hbytes;
    } t_verdict;

    class verdict_scoreboard;

        t_verdict    verdicts_due[$];
        int unsigned errors;

        // Mirror of the parser state and the accepted protocol register.
        t_proto accept_proto;
        t_idx   word_idx;
        t_idx   hdr_words;
        t_word  csum;
        bit     in_header;
        bit     ttl_zero;
        t_proto seen_proto;
        t_word  seen_len;

        function new();
            accept_proto = PROTO_RESET;
            word_idx     = '0;
            hdr_words    = '0;
            csum         = '0;
            in_header    = 1'b0;
            ttl_zero     = 1'b0;
            seen_proto   = '0;
            seen_len     = '0;
            errors       = 0;
        endfunction

        function void set_accept_proto(t_proto p);
            accept_proto = p;
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        // Note one accepted word and queue the verdict it completes, if any.
        function void note_word(t_word w, logic start);
            logic [3:0]     ver;
            logic [3:0]     ihl;
            logic [WordW:0] acc;
            t_verdict       v;
            if (start) begin
                ver        = w[15:12];
                ihl        = w[11:8];
                seen_proto = '0;
                seen_len   = '0;
                ttl_zero   = 1'b0;
                if (ver != IP_VERSION || ihl < IHL_MIN) begin
                    in_header   = 1'b0;
                    v.status    = (ver != IP_VERSION) ? ST_BAD_VERSION : ST_SHORT_HEADER;
                    v.proto     = '0;
                    v.total_len = '0;
                    v.hbytes    = {ihl, 2'b00};
                    verdicts_due.push_back(v);
                    return;
                end
                in_header = 1'b1;
                hdr_words = {ihl, 1'b0};
                word_idx  = IDX_LENGTH;
                csum      = w;
                return;
            end
            if (!in_header)
                return;
            acc  = {1'b0, csum} + {1'b0, w};
            csum = acc[WordW-1:0] + acc[WordW];
            if (word_idx == IDX_LENGTH)
                seen_len = w;
            if (word_idx == IDX_TTL_PROT) begin
                ttl_zero   = (w[15:8] == 8'd0);
                seen_proto = w[7:0];
            end
            word_idx = word_idx + 1'b1;
            if (word_idx == hdr_words) begin
                in_header = 1'b0;
                if (ttl_zero)
                    v.status = ST_TTL_ZERO;
                else if (csum != CSUM_GOOD)
                    v.status = ST_BAD_CSUM;
                else if (seen_proto != accept_proto)
                    v.status = ST_BAD_PROTO;
                else
                    v.status = ST_ACCEPT;
                v.proto     = seen_proto;
                v.total_len = seen_len;
                v.hbytes    = {hdr_words, 1'b0};
                verdicts_due.push_back(v);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_verdict(t_status st, t_proto pr, t_word len, t_hbytes hb);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict status=%0d with none outstanding", st));
                return;
            end
            want = verdicts_due.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d", st, want.status));
            if (pr !== want.proto)
                report_mismatch($sformatf("protocol %0d, predicted %0d", pr, want.proto));
            if (len !== want.total_len)
                report_mismatch($sformatf("total length %h, predicted %h", len,
                                          want.total_len));
            if (hb !== want.hbytes)
                report_mismatch($sformatf("header bytes %0d, predicted %0d", hb,
                                          want.hbytes));
        endtask

    endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for ipv4_header_validator: drives directed and random datagram
// streams with random idling on both channels and checks every verdict.
// Depends on ipv4hv_pkg, ipv4hv_tb_pkg and the validator RTL.
`timescale 1ns / 100ps
module tb;

    import ipv4hv_pkg::*;
    import ipv4hv_tb_pkg::*;

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_cfg_we      = 1'b0;
    t_proto  i_cfg_data    = '0;
    logic    i_in_valid    = 1'b0;
    t_word   i_header_word = '0;
    logic    i_start_req   = 1'b0;
    logic    i_out_ready   = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_status o_status;
    t_proto  o_protocol;
    t_word   o_total_length;
    t_hbytes o_header_bytes;

    verdict_scoreboard sb;

    // Accepted protocol as last written; random datagrams aim at it half the time.
    t_proto      cur_proto   = PROTO_RESET;
    // Set during one phase to run both channels flat out.
    bit          steady      = 1'b0;
    // Header words sent in the current phase; stray and trailing words are not counted.
    int unsigned header_sent = 0;
    int unsigned stall_left  = 0;

    ipv4_header_validator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_header_word  (i_header_word),
        .i_start_req    (i_start_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_protocol     (o_protocol),
        .o_total_length (o_total_length),
        .o_header_bytes (o_header_bytes)
    );

    always #2 i_clk = ~i_clk;

    // Idle length: mostly none, often a few cycles, now and then a long stretch.
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check each transfer against the oldest prediction, then pick
    // the next ready value. Outputs are read as they stood before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_verdict(o_status, o_protocol, o_total_length, o_header_bytes);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = idle_len();
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one word after a random gap; hold it until the transfer happens.
    task automatic send_item(input t_word w, input logic s);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_header_word <= w;
        i_start_req   <= s;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_word(w, s);
    endtask

    // Drop valid and hold until every predicted verdict has arrived, then let the
    // block settle before anything else happens.
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Change the accepted protocol only with the block idle.
    task automatic write_proto(input t_proto p);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_accept_proto(p);
        cur_proto = p;
    endtask

    // Build a well-formed header with a correct checksum, optionally corrupt one
    // bit, and send its first 'keep' words followed by 'tail' payload words.
    task automatic send_datagram(input logic [3:0] ihl, input t_proto proto,
                                 input logic [7:0] ttl, input bit bad_csum,
                                 input int keep, input int tail);
        t_word          hdr [0:29];
        logic [WordW:0] acc;
        t_word          s;
        int             n;
        int             k;
        n = ihl * 2;
        for (int i = 0; i < 30; i++)
            hdr[i] = t_word'($urandom);
        hdr[0] = {IP_VERSION, ihl, hdr[0][7:0]};
        hdr[4] = {ttl, proto};
        hdr[5] = '0;
        s = '0;
        for (int i = 0; i < n; i++) begin
            acc = {1'b0, s} + {1'b0, hdr[i]};
            s   = acc[WordW-1:0] + acc[WordW];
        end
        hdr[5] = ~s;
        if (bad_csum) begin
            k      = $urandom_range(1, n - 1);
            hdr[k] = hdr[k] ^ (t_word'(1) << $urandom_range(0, 15));
        end
        for (int i = 0; i < keep; i++) begin
            send_item(hdr[i], i == 0);
            header_sent++;
        end
        for (int i = 0; i < tail; i++)
            send_item(t_word'($urandom), 1'b0);
    endtask

    // One random unit of traffic: mostly datagrams with random content, some
    // malformed first words and some stray words while discarding.
    task automatic random_unit();
        int         r;
        int         keep;
        int         tail;
        logic [3:0] ihl;
        logic [7:0] ttl;
        t_proto     proto;
        t_word      w;
        r = $urandom_range(0, 99);
        if (r < 7) begin
            // bad version: force the top nibble away from four
            w = t_word'($urandom);
            if (w[15:12] == IP_VERSION)
                w[15:12] = w[15:12] ^ 4'($urandom_range(1, 15));
            send_item(w, 1'b1);
            header_sent++;
        end else if (r < 13) begin
            // short header: right version, IHL below five
            w = {IP_VERSION, 4'($urandom_range(0, 4)), 8'($urandom)};
            send_item(w, 1'b1);
            header_sent++;
        end else if (r < 17) begin
            send_item(t_word'($urandom), 1'b0);
        end else begin
            ihl   = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(6, 15));
            ttl   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
            proto = $urandom_range(0, 1) ? cur_proto : t_proto'($urandom);
            keep  = ihl * 2;
            tail  = 0;
            // cut some headers short; the next start abandons them
            if ($urandom_range(0, 9) == 0)
                keep = $urandom_range(1, ihl * 2 - 1);
            else if ($urandom_range(0, 3) == 0)
                tail = $urandom_range(1, 4);
            send_datagram(ihl, proto, ttl, $urandom_range(0, 6) == 0, keep, tail);
        end
    endtask

    initial begin
        t_proto proto_plan [0:5];
        sb = new();
        proto_plan = '{PROTO_RESET, 8'd0, 8'd255, 8'd6, t_proto'($urandom), 8'd17};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: malformed first words at the field extremes.
        send_item(16'h0000, 1'b1);   // version zero, IHL zero
        send_item(16'hFFFF, 1'b1);   // bad version with the largest IHL
        send_item(16'h4000, 1'b1);   // short header, IHL zero
        send_item(16'h44FF, 1'b1);   // short header, IHL four
        send_item(16'h1234, 1'b0);   // discarded: no start
        // Minimal good header for ICMP, then payload words that must be ignored.
        send_datagram(4'd5, PROTO_RESET, 8'hFF, 1'b0, 10, 2);
        // Header abandoned part way by the next start.
        send_datagram(4'd5, 8'd6, 8'd1, 1'b0, 3, 0);
        // TTL zero takes priority over a bad checksum.
        send_datagram(4'd5, PROTO_RESET, 8'd0, 1'b1, 10, 0);

        // Random phases, one per accepted protocol; each write waits for the
        // block to go quiet, which also holds the sender off until drained.
        for (int p = 0; p < 6; p++) begin
            if (p > 0)
                write_proto(proto_plan[p]);
            steady      = (p == 3);
            header_sent = 0;
            while (header_sent < 145)
                random_unit();
        end
        steady = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
